// ===== rtl/adam_pkg.sv =====
// Shared types and constants of the Adam optimizer update engine.
package adam_pkg;

  localparam int IDX_W   = 8;
  localparam int GRAD_W  = 32;
  localparam int DELTA_W = 32;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int DEN_W   = 49;
  localparam int DIV_CW  = 7;
  localparam int Q_W     = 64;

  localparam logic CMD_START = 1'b0;

  localparam logic [31:0] ONE_Q31        = 32'h8000_0000;
  localparam logic [15:0] BETA_ONE_RST   = 16'd58982;
  localparam logic [15:0] BETA_TWO_RST   = 16'd65470;
  localparam logic [23:0] LEARN_RATE_RST = 24'd16777;
  localparam logic [31:0] EPSILON_RST    = 32'd43;

  typedef enum logic [1:0] {
    REG_BETA_ONE   = 2'd0,
    REG_BETA_TWO   = 2'd1,
    REG_LEARN_RATE = 2'd2,
    REG_EPSILON    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  hi;
    logic [Q_W-1:0]    lo;
    logic [DIV_CW-1:0] nbits;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/adam_grad_if.sv =====
// Gradient input channel with valid/ready handshake.
interface adam_grad_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic                             first_in_step;
  logic [adam_pkg::IDX_W-1:0]       param_index;
  logic signed [adam_pkg::GRAD_W-1:0] gradient;

  modport source (output valid, cmd, first_in_step, param_index, gradient, input ready);
  modport sink (input valid, cmd, first_in_step, param_index, gradient, output ready);
endinterface

// ===== rtl/adam_delta_if.sv =====
// Parameter offset result channel with valid/ready handshake.
interface adam_delta_if;
  logic                                valid;
  logic                                ready;
  logic [adam_pkg::IDX_W-1:0]          out_index;
  logic signed [adam_pkg::DELTA_W-1:0] parameter_delta;

  modport source (output valid, out_index, parameter_delta, input ready);
  modport sink (input valid, out_index, parameter_delta, output ready);
endinterface

// ===== rtl/adam_ram.sv =====
// Generic single-port-write, registered-read RAM.
module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/adam_div.sv =====
// Bit-serial restoring divider shared by the three divisions of an update.
module adam_div (
  input  logic               clk,
  input  logic               rst_n,
  input  adam_pkg::div_req_t req,
  output adam_pkg::div_rsp_t rsp
);
  localparam int DW = adam_pkg::DEN_W;
  localparam int QW = adam_pkg::Q_W;

  logic                        busy_r;
  logic                        done_r;
  logic [adam_pkg::DIV_CW-1:0] cnt_r;
  logic [DW-1:0]               rem_r;
  logic [QW-1:0]               sh_r;
  logic [QW-1:0]               quo_r;
  logic [DW:0]                 trial;
  logic                        fits;

  assign trial = {rem_r, sh_r[QW-1]};
  assign fits  = trial >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= req.nbits;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == adam_pkg::DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      sh_r  <= req.lo;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, req.den}) : trial[DW-1:0];
      sh_r  <= {sh_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// ===== rtl/adam_optimizer_update_core.sv =====
// Adam optimizer update engine: moment stores, bias correction and offset.
//
// in_if carries one beat per command. A start beat (cmd low) clears both
// moment stores and sets the beta powers to one; it gives no result. A
// gradient beat updates the moments of param_index and gives one beat on
// out_if with the offset to add to that parameter. A gradient whose index
// is not below PARAM_COUNT is dropped without a result.
// Moments live in two RAMs; every update is a read, modify and write back.
// A gradient beat runs the shared bit-serial divider for up to 63, 64 and
// 32 steps for the three divisions and the square root for 32 steps; a
// start beat clears one RAM row per cycle. in_if.ready is high only when
// no beat is in progress. After reset the RAMs are cleared the same way,
// with in_if.ready low. Configuration is written through the APB port,
// reads return the register value. The result sits in an output
// register; a stalled receiver holds it and the next beat is still
// accepted, but that beat cannot finish until the register is free.
module adam_optimizer_update_core #(
  parameter int PARAM_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  adam_grad_if.sink                     in_if,
  adam_delta_if.source                  out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [adam_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [adam_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [adam_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int DW = adam_pkg::DEN_W;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_CLEAR = 17'h00002,
    ST_POW   = 17'h00004,
    ST_MOM1  = 17'h00008,
    ST_MOM2  = 17'h00010,
    ST_MOM3  = 17'h00020,
    ST_MOM4  = 17'h00040,
    ST_MOM5  = 17'h00080,
    ST_WB    = 17'h00100,
    ST_DIV1  = 17'h00200,
    ST_DIV2  = 17'h00400,
    ST_SQRT  = 17'h00800,
    ST_MUL0  = 17'h01000,
    ST_MUL1  = 17'h02000,
    ST_MUL2  = 17'h04000,
    ST_DIV3  = 17'h08000,
    ST_FIN   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]  clr_cnt_r;
  logic [15:0]    b1_r, b2_r;
  logic [23:0]    lr_r;
  logic [31:0]    eps_r;
  logic [31:0]    p1_r, p2_r;
  logic           div_run_r;
  logic           out_valid_r;

  logic                 fis_r;
  logic [7:0]           idx_r;
  logic signed [31:0]   g_r;
  logic signed [48:0]   pa_r;
  logic signed [49:0]   pb_r;
  logic [62:0]          gg_r;
  logic signed [31:0]   m_r;
  logic [46:0]          gsq_r;
  logic [63:0]          va_r, vb_r;
  logic [47:0]          v_r;
  logic [62:0]          mag_r;
  logic [63:0]          sq_x_r;
  logic [33:0]          sq_rem_r;
  logic [31:0]          sq_res_r;
  logic [4:0]           sq_cnt_r;
  logic [DW-1:0]        den_r;
  logic [94:0]          acc_r;
  logic [62:0]          mp_r;
  logic [31:0]          q_r;
  logic [7:0]           out_idx_r;
  logic [31:0]          out_delta_r;

  logic                 in_acc, in_range, cfg_wr, out_free;
  adam_pkg::cfg_idx_t   cfg_idx;
  adam_pkg::div_req_t   div_req;
  adam_pkg::div_rsp_t   div_rsp;

  logic [AW-1:0]        idx_addr, mem_waddr;
  logic                 mem_we;
  logic [31:0]          mem_wm, rd_m;
  logic [47:0]          mem_wv, rd_v;

  logic [47:0]          pw1_sum, pw2_sum;
  logic [16:0]          w1, w2;
  logic signed [48:0]   pa_c;
  logic signed [49:0]   pb_c;
  logic signed [63:0]   gprod;
  logic signed [51:0]   msum;
  logic [63:0]          gsum;
  logic [63:0]          va_c, vb_c;
  logic [64:0]          vsum;
  logic [31:0]          d1, d2;
  logic                 m_neg;
  logic [31:0]          m_abs, limit;
  logic                 v_sat, q_sat;
  logic [35:0]          sq_t, sq_trial;
  logic                 sq_fit;
  logic [48:0]          den_sum;
  logic [31:0]          a_op;
  logic [63:0]          mul_lo;
  logic [62:0]          mul_hi;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign in_range    = int'(in_if.param_index) < PARAM_COUNT;
  assign out_free    = !out_valid_r || out_if.ready;

  assign out_if.valid           = out_valid_r;
  assign out_if.out_index       = out_idx_r;
  assign out_if.parameter_delta = out_delta_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = adam_pkg::cfg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      adam_pkg::REG_BETA_ONE:   cfg_prdata = {16'b0, b1_r};
      adam_pkg::REG_BETA_TWO:   cfg_prdata = {16'b0, b2_r};
      adam_pkg::REG_LEARN_RATE: cfg_prdata = {8'b0, lr_r};
      adam_pkg::REG_EPSILON:    cfg_prdata = eps_r;
      default:                  cfg_prdata = '0;
    endcase
  end

  assign idx_addr  = AW'(idx_r);
  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_WB);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : idx_addr;
  assign mem_wm    = (state_r == ST_CLEAR) ? 32'd0 : m_r;
  assign mem_wv    = (state_r == ST_CLEAR) ? 48'd0 : v_r;

  adam_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_first_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wm),
    .raddr(idx_addr), .rdata(rd_m)
  );

  adam_ram #(.WIDTH(48), .DEPTH(PARAM_COUNT)) u_second_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wv),
    .raddr(idx_addr), .rdata(rd_v)
  );

  adam_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign pw1_sum = p1_r * b1_r + 48'd32768;
  assign pw2_sum = p2_r * b2_r + 48'd32768;
  assign w1      = 17'h10000 - {1'b0, b1_r};
  assign w2      = 17'h10000 - {1'b0, b2_r};
  assign pa_c    = $signed({1'b0, b1_r}) * $signed(rd_m);
  assign pb_c    = $signed({1'b0, w1}) * g_r;
  assign gprod   = g_r * g_r;
  assign msum    = 52'(pa_r) + 52'(pb_r) + 52'sd32768;
  assign gsum    = {1'b0, gg_r} + 64'd32768;
  assign va_c    = b2_r * rd_v;
  assign vb_c    = w2 * gsq_r;
  assign vsum    = {1'b0, va_r} + {1'b0, vb_r} + 65'd32768;
  assign d1      = adam_pkg::ONE_Q31 - p1_r;
  assign d2      = adam_pkg::ONE_Q31 - p2_r;
  assign m_neg   = m_r[31];
  assign m_abs   = m_neg ? 32'(-m_r) : 32'(m_r);
  assign limit   = m_neg ? 32'h7FFF_FFFF : 32'h8000_0000;
  assign v_sat   = {17'b0, v_r[47:33]} >= d2;
  assign q_sat   = acc_r[94:32] >= {14'b0, den_r};
  assign sq_t     = {sq_rem_r, sq_x_r[63:62]};
  assign sq_trial = {2'b0, sq_res_r, 2'b01};
  assign sq_fit   = sq_t >= sq_trial;
  assign den_sum  = {1'b0, sq_res_r, 16'b0} + {17'b0, eps_r};
  assign a_op     = {lr_r, 8'b0};
  assign mul_lo   = a_op * mag_r[31:0];
  assign mul_hi   = a_op * mag_r[62:32];

  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.hi    = '0;
    div_req.lo    = '0;
    div_req.nbits = '0;
    div_req.den   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.cmd == adam_pkg::CMD_START) begin
            state_nxt = ST_CLEAR;
          end else if (in_range) begin
            state_nxt = ST_POW;
          end
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(PARAM_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POW:  state_nxt = ST_MOM1;
      ST_MOM1: state_nxt = ST_MOM2;
      ST_MOM2: state_nxt = ST_MOM3;
      ST_MOM3: state_nxt = ST_MOM4;
      ST_MOM4: state_nxt = ST_MOM5;
      ST_MOM5: state_nxt = ST_WB;
      ST_WB: begin
        state_nxt = ((d1 == 32'd0) || (d2 == 32'd0)) ? ST_FIN : ST_DIV1;
      end
      ST_DIV1: begin
        div_req.start = !div_run_r;
        div_req.lo    = {m_abs, 32'b0};
        div_req.nbits = adam_pkg::DIV_CW'(63);
        div_req.den   = DW'(d1);
        if (div_run_r && div_rsp.done) begin
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        div_req.start = !div_run_r && !v_sat;
        div_req.hi    = DW'(v_r[47:33]);
        div_req.lo    = {v_r[32:0], 31'b0};
        div_req.nbits = adam_pkg::DIV_CW'(64);
        div_req.den   = DW'(d2);
        if ((!div_run_r && v_sat) || (div_run_r && div_rsp.done)) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_cnt_r == 5'd31) begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DIV3;
      ST_DIV3: begin
        div_req.start = !div_run_r && !q_sat;
        div_req.hi    = acc_r[32+DW-1:32];
        div_req.lo    = {acc_r[31:0], 32'b0};
        div_req.nbits = adam_pkg::DIV_CW'(32);
        div_req.den   = den_r;
        if ((!div_run_r && q_sat) || (div_run_r && div_rsp.done)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      p1_r        <= adam_pkg::ONE_Q31;
      p2_r        <= adam_pkg::ONE_Q31;
      b1_r        <= adam_pkg::BETA_ONE_RST;
      b2_r        <= adam_pkg::BETA_TWO_RST;
      lr_r        <= adam_pkg::LEARN_RATE_RST;
      eps_r       <= adam_pkg::EPSILON_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          adam_pkg::REG_BETA_ONE:   b1_r  <= cfg_pwdata[15:0];
          adam_pkg::REG_BETA_TWO:   b2_r  <= cfg_pwdata[15:0];
          adam_pkg::REG_LEARN_RATE: lr_r  <= cfg_pwdata[23:0];
          adam_pkg::REG_EPSILON:    eps_r <= cfg_pwdata;
          default:                  eps_r <= eps_r;
        endcase
      end
      if (state_r == ST_IDLE && in_acc && in_if.cmd == adam_pkg::CMD_START) begin
        p1_r      <= adam_pkg::ONE_Q31;
        p2_r      <= adam_pkg::ONE_Q31;
        clr_cnt_r <= '0;
      end else if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end else if (state_r == ST_POW && fis_r) begin
        p1_r <= pw1_sum[47:16];
        p2_r <= pw2_sum[47:16];
      end
      if (state_r != state_nxt) begin
        div_run_r <= 1'b0;
      end else if (div_req.start) begin
        div_run_r <= 1'b1;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        fis_r <= in_if.first_in_step;
        idx_r <= in_if.param_index;
        g_r   <= in_if.gradient;
      end
      ST_MOM1: begin
        pa_r <= pa_c;
        pb_r <= pb_c;
      end
      ST_MOM2: begin
        m_r  <= msum[47:16];
        gg_r <= gprod[62:0];
      end
      ST_MOM3: begin
        gsq_r <= gsum[62:16];
        va_r  <= va_c;
      end
      ST_MOM4: vb_r <= vb_c;
      ST_MOM5: v_r <= vsum[63:16];
      ST_WB: q_r <= 32'd0;
      ST_DIV1: begin
        if (div_run_r && div_rsp.done) begin
          mag_r <= div_rsp.quo[62:0];
        end
      end
      ST_DIV2: begin
        sq_rem_r <= '0;
        sq_res_r <= '0;
        sq_cnt_r <= '0;
        if (!div_run_r && v_sat) begin
          sq_x_r <= '1;
        end else if (div_run_r && div_rsp.done) begin
          sq_x_r <= div_rsp.quo;
        end
      end
      ST_SQRT: begin
        sq_rem_r <= sq_fit ? 34'(sq_t - sq_trial) : sq_t[33:0];
        sq_res_r <= {sq_res_r[30:0], sq_fit};
        sq_x_r   <= {sq_x_r[61:0], 2'b00};
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
      ST_MUL0: begin
        den_r <= (den_sum == '0) ? DW'(1) : den_sum;
        acc_r <= 95'(mul_lo);
      end
      ST_MUL1: mp_r <= mul_hi;
      ST_MUL2: acc_r <= acc_r + {mp_r, 32'b0};
      ST_DIV3: begin
        if (!div_run_r && q_sat) begin
          q_r <= limit;
        end else if (div_run_r && div_rsp.done) begin
          q_r <= (div_rsp.quo[31:0] > limit) ? limit : div_rsp.quo[31:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_idx_r   <= idx_r;
          out_delta_r <= m_neg ? q_r : (~q_r + 32'd1);
        end
      end
      default: begin
        den_r <= den_r;
      end
    endcase
  end
endmodule

// ===== rtl/adam_chk.sv =====
// Port-level assertions for the Adam optimizer update engine and their bind.
module adam_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_cmd,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [adam_pkg::IDX_W-1:0]   out_index,
  input logic [adam_pkg::DELTA_W-1:0] out_delta
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_delta))
    else $error("result beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted before the stores were cleared");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == adam_pkg::CMD_START |=> !in_ready)
    else $error("input accepted during the clearing pass");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat appeared with no update in progress");
endmodule

bind adam_optimizer_update_core adam_chk u_adam_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_if.valid),
  .in_ready(in_if.ready),
  .in_cmd(in_if.cmd),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_index(out_if.out_index),
  .out_delta(out_if.parameter_delta)
);
